// ----- rtl/scfc_pkg.sv -----
package scfc_pkg;

  localparam logic [2:0] CONV_DEC      = 3'd0;
  localparam logic [2:0] CONV_UNS      = 3'd1;
  localparam logic [2:0] CONV_OCT      = 3'd2;
  localparam logic [2:0] CONV_HEX      = 3'd3;
  localparam logic [2:0] CONV_WORD     = 3'd4;
  localparam logic [2:0] CONV_FIXED    = 3'd5;
  localparam logic [2:0] CONV_SET      = 3'd6;
  localparam logic [2:0] CONV_NODIGIT  = 3'd7;

  localparam logic [1:0] SIZE_INT   = 2'd0;
  localparam logic [1:0] SIZE_SHORT = 2'd1;
  localparam logic [1:0] SIZE_LONG  = 2'd2;

  localparam logic [1:0] PH_SKIP = 2'd0;
  localparam logic [1:0] PH_SIGN = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam logic [2:0] REG_CONVERSION   = 3'd0;
  localparam logic [2:0] REG_MAX_WIDTH    = 3'd1;
  localparam logic [2:0] REG_STORE_ENABLE = 3'd2;
  localparam logic [2:0] REG_RESULT_SIZE  = 3'd3;
  localparam logic [2:0] REG_SET_BITS_A   = 3'd4;
  localparam logic [2:0] REG_SET_BITS_B   = 3'd5;
  localparam logic [2:0] REG_SET_BITS_C   = 3'd6;
  localparam logic [2:0] REG_SET_BITS_D   = 3'd7;

  localparam logic [6:0]  MAX_NUMBER_CHARS = 7'd63;
  localparam logic [6:0]  TAKEN_SAT        = 7'd127;
  localparam logic [63:0] MIN_LONG         = 64'h8000_0000_0000_0000;

  localparam logic [7:0] CHAR_ZERO        = 8'd48;
  localparam logic [7:0] CHAR_NINE        = 8'd57;
  localparam logic [7:0] CHAR_UPPER_A     = 8'd65;
  localparam logic [7:0] CHAR_UPPER_F     = 8'd70;
  localparam logic [7:0] CHAR_LOWER_A     = 8'd97;
  localparam logic [7:0] CHAR_LOWER_F     = 8'd102;
  localparam logic [7:0] CHAR_UPPER_BIAS  = 8'd55;
  localparam logic [7:0] CHAR_LOWER_BIAS  = 8'd87;
  localparam logic [7:0] CHAR_PLUS        = 8'd43;
  localparam logic [7:0] CHAR_MINUS       = 8'd45;
  localparam logic [7:0] CHAR_SPACE       = 8'd32;
  localparam logic [7:0] CHAR_TAB         = 8'd9;
  localparam logic [7:0] CHAR_CR          = 8'd13;

  typedef struct packed {
    logic [2:0]   conversion;
    logic [15:0]  max_width;
    logic         store_enable;
    logic [1:0]   result_size;
    logic [255:0] set_bits;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [15:0] width_left;
    logic [63:0] accumulator;
    logic        negative;
    logic [6:0]  taken_count;
  } state_t;

  typedef struct packed {
    logic               consumed;
    logic               store_valid;
    logic [7:0]         store_char;
    logic               field_done;
    logic               matched;
    logic signed [63:0] value;
    logic               end_seen;
  } result_t;

endpackage

// ----- rtl/scfc_in_if.sv -----
interface scfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       at_end;
  logic       restart;

  modport source (output valid, ch, at_end, restart, input ready);
  modport sink (input valid, ch, at_end, restart, output ready);
endinterface

// ----- rtl/scfc_out_if.sv -----
interface scfc_out_if;
  logic               valid;
  logic               ready;
  logic               consumed;
  logic               store_valid;
  logic [7:0]         store_char;
  logic               field_done;
  logic               matched;
  logic signed [63:0] value;
  logic               end_seen;

  modport source (output valid, consumed, store_valid, store_char, field_done, matched,
                  value, end_seen, input ready);
  modport sink (input valid, consumed, store_valid, store_char, field_done, matched,
                value, end_seen, output ready);
endinterface

// ----- rtl/scfc_cfg_if.sv -----
interface scfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [63:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ----- rtl/scanf_field_converter_unit.sv -----
// Converts one scanf field (integer or string) from a character stream.
// The chars channel carries one character per item together with an
// end-of-input mark and a restart flag that opens a new field. The results
// channel returns exactly one item for every character item: whether the
// character was consumed, an optional character to store, and on the last
// item of a field the done flag, match flag, converted value and end flag.
// The cfg channel writes the conversion mode, width limit, store enable,
// result size and the four scanset words; it is always ready. It is to be
// written only while no item is in flight; the block does not enforce this.
// Each result item is registered and offered the cycle after its character;
// one character is taken every cycle while results are taken. Per-character
// work is a shift-add accumulate and a scanset lookup between the field
// state and the single result register; the field state loop sets that rate.
// A result waiting in the output register does not stop a new character as
// long as the receiver takes it in the same cycle; if the receiver stalls,
// the chars channel stalls with it and nothing is lost.
// Reset clears the field state and the output valid flag and loads the
// configuration defaults (decimal, no width limit, store on, int size).
module scanf_field_converter_unit (
  input logic       clk,
  input logic       rst,
  scfc_in_if.sink   chars,
  scfc_out_if.source results,
  scfc_cfg_if.sink  cfg
);
  import scfc_pkg::*;

  cfg_t    cfg_regs;
  state_t  st;
  state_t  st_next;
  result_t step_res;
  result_t res_q;
  logic    out_valid;
  logic    in_acc;

  scfc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  scfc_step u_step (
    .ch      (chars.ch),
    .at_end  (chars.at_end),
    .restart (chars.restart),
    .cfg     (cfg_regs),
    .st      (st),
    .st_next (st_next),
    .res     (step_res)
  );

  assign chars.ready = !out_valid || results.ready;
  assign in_acc      = chars.valid && chars.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else if (in_acc) begin
      st        <= st_next;
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_q <= step_res;
    end
  end

  assign results.valid       = out_valid;
  assign results.consumed    = res_q.consumed;
  assign results.store_valid = res_q.store_valid;
  assign results.store_char  = res_q.store_char;
  assign results.field_done  = res_q.field_done;
  assign results.matched     = res_q.matched;
  assign results.value       = res_q.value;
  assign results.end_seen    = res_q.end_seen;

  a_done_state: assert property (@(posedge clk) disable iff (rst)
    in_acc && step_res.field_done |=> st.phase == PH_DONE)
    else $error("field done without entering the done phase");

  a_store_consumes: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.store_valid |-> results.consumed && !results.end_seen)
    else $error("stored character not consumed");

  a_value_on_match: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.value != 64'sd0 |-> results.field_done && results.matched)
    else $error("value reported outside a matched field end");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    in_acc && st.phase == PH_DONE && !chars.restart |=> res_q == '0 && st == $past(st))
    else $error("finished field changed on a character");
endmodule

// ----- rtl/scfc_cfg_regs.sv -----
module scfc_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  scfc_cfg_if.sink       cfg,
  output scfc_pkg::cfg_t regs
);
  import scfc_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.conversion   <= CONV_DEC;
      regs.max_width    <= '0;
      regs.store_enable <= 1'b1;
      regs.result_size  <= SIZE_INT;
      regs.set_bits     <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_CONVERSION:   regs.conversion     <= cfg.data[2:0];
        REG_MAX_WIDTH:    regs.max_width      <= cfg.data[15:0];
        REG_STORE_ENABLE: regs.store_enable   <= cfg.data[0];
        REG_RESULT_SIZE:  regs.result_size    <= cfg.data[1:0];
        REG_SET_BITS_A:   regs.set_bits[63:0]    <= cfg.data;
        REG_SET_BITS_B:   regs.set_bits[127:64]  <= cfg.data;
        REG_SET_BITS_C:   regs.set_bits[191:128] <= cfg.data;
        REG_SET_BITS_D:   regs.set_bits[255:192] <= cfg.data;
        default: ;
      endcase
    end
  end
endmodule

// ----- rtl/scfc_step.sv -----
module scfc_step (
  input  logic              [7:0] ch,
  input  logic                    at_end,
  input  logic                    restart,
  input  scfc_pkg::cfg_t          cfg,
  input  scfc_pkg::state_t        st,
  output scfc_pkg::state_t        st_next,
  output scfc_pkg::result_t       res
);
  import scfc_pkg::*;

  logic        is_space;
  logic        is_num;
  logic        limited;
  logic        stop_char;
  logic [3:0]  digit;
  logic        digit_ok;
  logic [63:0] acc_scaled;
  logic [63:0] fin_val;
  logic        fin;
  logic        fin_end;
  state_t      s;

  assign is_space = (ch == CHAR_SPACE) || (ch >= CHAR_TAB && ch <= CHAR_CR);
  assign is_num   = (cfg.conversion <= CONV_HEX) || (cfg.conversion == CONV_NODIGIT);
  assign limited  = (cfg.max_width != 16'd0) || (cfg.conversion == CONV_FIXED);
  assign stop_char = ((cfg.conversion == CONV_WORD) && is_space) ||
                     ((cfg.conversion == CONV_SET) && cfg.set_bits[ch]);

  // Digit decode; hex letters are valid only in hex mode.
  always_comb begin
    digit    = '0;
    digit_ok = 1'b0;
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      digit    = 4'(ch - CHAR_ZERO);
      digit_ok = (cfg.conversion == CONV_OCT) ? (digit < 4'd8) :
                 (cfg.conversion != CONV_NODIGIT);
    end else if (cfg.conversion == CONV_HEX && ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F) begin
      digit    = 4'(ch - CHAR_UPPER_BIAS);
      digit_ok = 1'b1;
    end else if (cfg.conversion == CONV_HEX && ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_F) begin
      digit    = 4'(ch - CHAR_LOWER_BIAS);
      digit_ok = 1'b1;
    end
  end

  always_comb begin
    unique case (cfg.conversion)
      CONV_OCT: acc_scaled = {s.accumulator[60:0], 3'b000};
      CONV_HEX: acc_scaled = {s.accumulator[59:0], 4'b0000};
      default:  acc_scaled = {s.accumulator[60:0], 3'b000} + {s.accumulator[62:0], 1'b0};
    endcase
  end

  always_comb begin
    fin_val = s.accumulator;
    if (s.negative && fin_val != MIN_LONG) begin
      fin_val = 64'(64'd0 - fin_val);
    end
    unique case (cfg.result_size)
      SIZE_SHORT: fin_val = {{48{fin_val[15]}}, fin_val[15:0]};
      SIZE_LONG:  fin_val = fin_val;
      default:    fin_val = {{32{fin_val[31]}}, fin_val[31:0]};
    endcase
  end

  always_comb begin
    s = st;
    if (restart) begin
      s.phase       = PH_SKIP;
      s.width_left  = (cfg.conversion == CONV_FIXED && cfg.max_width == 16'd0) ? 16'd1 :
                      cfg.max_width;
      s.accumulator = '0;
      s.negative    = 1'b0;
      s.taken_count = '0;
    end
    st_next = s;
    res     = '0;
    fin     = 1'b0;
    fin_end = 1'b0;
    if (s.phase != PH_DONE) begin
      if (s.phase == PH_SKIP && cfg.conversion != CONV_FIXED && cfg.conversion != CONV_SET &&
          !at_end && is_space) begin
        res.consumed = 1'b1;
      end else begin
        if (s.phase == PH_SKIP) begin
          st_next.phase = is_num ? PH_SIGN : PH_BODY;
        end
        if (at_end) begin
          fin     = 1'b1;
          fin_end = 1'b1;
        end else if (limited && s.width_left == 16'd0) begin
          fin = 1'b1;
        end else if (is_num) begin
          st_next.phase = PH_BODY;
          if (st_next.phase == PH_BODY && s.phase != PH_BODY &&
              cfg.conversion != CONV_NODIGIT && (ch == CHAR_PLUS || ch == CHAR_MINUS)) begin
            if (ch == CHAR_MINUS && cfg.conversion == CONV_UNS) begin
              fin = 1'b1;
            end else begin
              st_next.negative = (ch == CHAR_MINUS);
              if (limited) begin
                st_next.width_left = 16'(s.width_left - 16'd1);
              end
              res.consumed = 1'b1;
            end
          end else if (s.taken_count >= MAX_NUMBER_CHARS || !digit_ok) begin
            fin = 1'b1;
          end else begin
            st_next.accumulator = 64'(acc_scaled + {60'd0, digit});
            st_next.taken_count = 7'(s.taken_count + 7'd1);
            if (limited) begin
              st_next.width_left = 16'(s.width_left - 16'd1);
            end
            res.consumed = 1'b1;
          end
        end else if (stop_char) begin
          fin = 1'b1;
        end else begin
          res.consumed = 1'b1;
          if (cfg.store_enable) begin
            res.store_valid = 1'b1;
            res.store_char  = ch;
          end
          if (s.taken_count < TAKEN_SAT) begin
            st_next.taken_count = 7'(s.taken_count + 7'd1);
          end
          if (limited) begin
            st_next.width_left = 16'(s.width_left - 16'd1);
            if (s.width_left == 16'd1) begin
              st_next.phase  = PH_DONE;
              res.field_done = 1'b1;
              res.matched    = 1'b1;
            end
          end
        end
      end
    end
    if (fin) begin
      st_next.phase  = PH_DONE;
      res.field_done = 1'b1;
      res.matched    = (s.taken_count != 7'd0);
      res.end_seen   = fin_end;
      if (is_num && cfg.conversion != CONV_NODIGIT && cfg.store_enable &&
          s.taken_count != 7'd0) begin
        res.value = fin_val;
      end
    end
  end
endmodule

// ----- dv/scanf_field_converter_unit_test.sv -----
`timescale 1ns / 1ps

module scanf_field_converter_unit_test;
  import scfc_pkg::*;

  localparam int ITEM_TARGET    = 1950;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int MAX_GAP        = 17;

  typedef struct {
    logic        is_write;
    logic [2:0]  addr;
    logic [63:0] data;
    logic [7:0]  ch;
    logic        at_end;
    logic        restart;
    logic        typed;
    result_t     want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  scfc_in_if  chars_if ();
  scfc_out_if results_if ();
  scfc_cfg_if cfg_if ();

  scanf_field_converter_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  always #4 clk = ~clk;

  cfg_t cur_cfg = '{conversion: CONV_DEC, max_width: '0, store_enable: 1'b1,
                    result_size: SIZE_INT, set_bits: '0};
  state_t fld = '{phase: PH_SKIP, default: '0};

  result_t pending_results[$];
  int      mismatches = 0;
  int      chars_sent = 0;
  bit      steady = 1'b0;

  function automatic bit is_blank(logic [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic int digit_value(logic [7:0] c, int base);
    int d;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) d = int'(c) - int'(CHAR_ZERO);
    else if (base == 16 && c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
      d = int'(c) - int'(CHAR_UPPER_BIAS);
    else if (base == 16 && c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
      d = int'(c) - int'(CHAR_LOWER_BIAS);
    else return -1;
    return (d < base) ? d : -1;
  endfunction

  function automatic result_t close_field(bit is_num, bit ran_out);
    result_t r;
    logic [63:0] v;
    r = '0;
    v = '0;
    fld.phase = PH_DONE;
    r.field_done = 1'b1;
    r.matched = fld.taken_count != 0;
    r.end_seen = ran_out;
    if (is_num && cur_cfg.conversion != CONV_NODIGIT && cur_cfg.store_enable &&
        fld.taken_count != 0) begin
      v = fld.accumulator;
      if (fld.negative && v != MIN_LONG) v = -v;
      case (cur_cfg.result_size)
        SIZE_SHORT: v = {{48{v[15]}}, v[15:0]};
        SIZE_LONG: ;
        default: v = {{32{v[31]}}, v[31:0]};
      endcase
    end
    r.value = v;
    return r;
  endfunction

  function automatic result_t convert_char(logic [7:0] c, logic ran_out, logic restart);
    result_t r;
    logic [2:0] conv;
    bit is_num;
    bit limited;
    int base;
    int d;
    r = '0;
    if (restart) begin
      fld = '0;
      fld.phase = PH_SKIP;
      fld.width_left = (cur_cfg.conversion == CONV_FIXED && cur_cfg.max_width == 0) ?
                       16'd1 : cur_cfg.max_width;
    end
    if (fld.phase == PH_DONE) return r;
    conv = cur_cfg.conversion;
    is_num = conv <= CONV_HEX || conv == CONV_NODIGIT;
    limited = cur_cfg.max_width != 0 || conv == CONV_FIXED;
    if (fld.phase == PH_SKIP) begin
      if (conv != CONV_FIXED && conv != CONV_SET && !ran_out && is_blank(c)) begin
        r.consumed = 1'b1;
        return r;
      end
      fld.phase = is_num ? PH_SIGN : PH_BODY;
    end
    if (ran_out) return close_field(is_num, 1'b1);
    if (limited && fld.width_left == 0) return close_field(is_num, 1'b0);
    if (is_num) begin
      case (conv)
        CONV_OCT: base = 8;
        CONV_HEX: base = 16;
        CONV_NODIGIT: base = 0;
        default: base = 10;
      endcase
      if (fld.phase == PH_SIGN) begin
        fld.phase = PH_BODY;
        if (conv != CONV_NODIGIT && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
          if (c == CHAR_MINUS && conv == CONV_UNS) return close_field(1'b1, 1'b0);
          fld.negative = c == CHAR_MINUS;
          if (limited) fld.width_left--;
          r.consumed = 1'b1;
          return r;
        end
      end
      if (fld.taken_count >= MAX_NUMBER_CHARS) return close_field(1'b1, 1'b0);
      d = digit_value(c, base);
      if (d < 0) return close_field(1'b1, 1'b0);
      fld.accumulator = fld.accumulator * 64'(base) + 64'(d);
      fld.taken_count++;
      if (limited) fld.width_left--;
      r.consumed = 1'b1;
      return r;
    end
    // A blank in word mode, or a character whose scanset bit is set in set mode, ends the field and is handed back.
    if ((conv == CONV_WORD && is_blank(c)) || (conv == CONV_SET && cur_cfg.set_bits[c]))
      return close_field(1'b0, 1'b0);
    r.consumed = 1'b1;
    if (cur_cfg.store_enable) begin
      r.store_valid = 1'b1;
      r.store_char = c;
    end
    if (fld.taken_count < TAKEN_SAT) fld.taken_count++;
    if (limited) begin
      fld.width_left--;
      if (fld.width_left == 0) begin
        fld.phase = PH_DONE;
        r.field_done = 1'b1;
        r.matched = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic result_t outcome(logic c, logic sv, logic [7:0] sc, logic done,
                                      logic m, logic [63:0] v, logic e);
    result_t r;
    r.consumed = c;
    r.store_valid = sv;
    r.store_char = sc;
    r.field_done = done;
    r.matched = m;
    r.value = v;
    r.end_seen = e;
    return r;
  endfunction

  function automatic plan_row_t plan_char(logic [7:0] c, logic e, logic r);
    plan_row_t row;
    row.is_write = 1'b0;
    row.addr = '0;
    row.data = '0;
    row.ch = c;
    row.at_end = e;
    row.restart = r;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t plan_check(logic [7:0] c, logic e, logic r, result_t want);
    plan_row_t row;
    row = plan_char(c, e, r);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic plan_row_t plan_write(logic [2:0] addr, logic [63:0] data);
    plan_row_t row;
    row = plan_char(8'h00, 1'b0, 1'b0);
    row.is_write = 1'b1;
    row.addr = addr;
    row.data = data;
    return row;
  endfunction

  function automatic int draw_gap();
    if (steady || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [7:0] blank_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CHAR_SPACE : CHAR_TAB + 8'(k);
  endfunction

  function automatic logic [7:0] digit_char(int base);
    int d;
    d = $urandom_range(0, base - 1);
    if (d < 10) return CHAR_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(d - 10);
  endfunction

  function automatic string boundary_digits(int base);
    case (base)
      8: begin
        case ($urandom_range(0, 2))
          0: return "1000000000000000000000";
          1: return "1777777777777777777777";
          default: return "37777777777";
        endcase
      end
      16: begin
        case ($urandom_range(0, 3))
          0: return "8000000000000000";
          1: return "FFFFFFFFFFFFFFFF";
          2: return "ffffffff";
          default: return "8000";
        endcase
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return "9223372036854775808";
          1: return "18446744073709551615";
          2: return "2147483648";
          3: return "32768";
          default: return "99999999999999999999";
        endcase
      end
    endcase
  endfunction

  function automatic logic [63:0] with_junk(logic [63:0] v, int bits);
    if ($urandom_range(0, 3) != 0) return v;
    return ({$urandom, $urandom} << bits) | v;
  endfunction

  task automatic push_char(logic [7:0] c, logic ran_out, logic restart, bit typed = 1'b0,
                           result_t want = '0);
    int gap;
    result_t predicted;
    gap = draw_gap();
    if (gap > 0) begin
      chars_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    chars_if.valid = 1'b1;
    chars_if.ch = c;
    chars_if.at_end = ran_out;
    chars_if.restart = restart;
    do @(posedge clk); while (!chars_if.ready);
    predicted = convert_char(c, ran_out, restart);
    pending_results.push_back(typed ? want : predicted);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    chars_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [63:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.addr = addr;
    cfg_if.data = data;
    do @(posedge clk); while (!cfg_if.ready);
    case (addr)
      REG_CONVERSION: cur_cfg.conversion = data[2:0];
      REG_MAX_WIDTH: cur_cfg.max_width = data[15:0];
      REG_STORE_ENABLE: cur_cfg.store_enable = data[0];
      REG_RESULT_SIZE: cur_cfg.result_size = data[1:0];
      default: cur_cfg.set_bits[int'(addr - REG_SET_BITS_A) * 64 +: 64] = data;
    endcase
    @(negedge clk);
  endtask

  task automatic reconfigure();
    logic [2:0] conv;
    logic [15:0] w;
    logic [63:0] bits;
    conv = 3'($urandom_range(0, 7));
    steady = $urandom_range(0, 3) == 0;
    settle();
    write_reg(REG_CONVERSION, with_junk(64'(conv), 3));
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: w = '0;
        4, 5, 6, 7: w = 16'($urandom_range(1, 8));
        8: w = 16'hFFFF;
        default: w = 16'($urandom);
      endcase
      write_reg(REG_MAX_WIDTH, with_junk(64'(w), 16));
    end
    if ($urandom_range(0, 1))
      write_reg(REG_STORE_ENABLE, with_junk(64'($urandom_range(0, 3) != 0), 1));
    if ($urandom_range(0, 1))
      write_reg(REG_RESULT_SIZE, with_junk(64'($urandom_range(0, 3)), 2));
    for (int k = 0; k < 4; k++) begin
      if (conv == CONV_SET || $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0: bits = '0;
          1: bits = '1;
          default: bits = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        endcase
        write_reg(3'(REG_SET_BITS_A + k), bits);
      end
    end
    cfg_if.valid = 1'b0;
  endtask

  task automatic send_field();
    logic [7:0] text[$];
    logic [2:0] conv;
    string lit;
    int n;
    int base;
    bit ran_out;
    conv = cur_cfg.conversion;
    ran_out = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6))
        push_char(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
      return;
    end
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) text.push_back(blank_char());
    if (conv <= CONV_HEX || conv == CONV_NODIGIT) begin
      base = (conv == CONV_OCT) ? 8 : (conv == CONV_HEX) ? 16 : 10;
      case ($urandom_range(0, 3))
        0: text.push_back(CHAR_PLUS);
        1: text.push_back(CHAR_MINUS);
        default: ;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        lit = boundary_digits(base);
        for (int i = 0; i < lit.len(); i++) text.push_back(lit[i]);
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 20);
        repeat (n) text.push_back(digit_char(base));
      end
    end else begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 140) : $urandom_range(0, 16);
      repeat (n)
        text.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(33, 126)));
    end
    case ($urandom_range(0, 3))
      0: ran_out = 1'b1;
      1: text.push_back(blank_char());
      default: text.push_back(8'($urandom));
    endcase
    foreach (text[i]) push_char(text[i], 1'b0, i == 0);
    if (ran_out) push_char(8'($urandom), 1'b1, text.size() == 0);
    repeat ($urandom_range(0, 2)) push_char(8'($urandom), 1'b0, 1'b0);
  endtask

  initial begin : result_check
    int gap;
    result_t got;
    result_t want;
    results_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        results_if.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      results_if.ready = 1'b1;
      do @(posedge clk); while (!results_if.valid);
      got.consumed = results_if.consumed;
      got.store_valid = results_if.store_valid;
      got.store_char = results_if.store_char;
      got.field_done = results_if.field_done;
      got.matched = results_if.matched;
      got.value = results_if.value;
      got.end_seen = results_if.end_seen;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result item with nothing pending", $time);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch want cons=%0b st=%0b/%02h done=%0b match=%0b val=%016h end=%0b",
                     $time, want.consumed, want.store_valid, want.store_char,
                     want.field_done, want.matched, want.value, want.end_seen);
            $display("%0t:          got  cons=%0b st=%0b/%02h done=%0b match=%0b val=%016h end=%0b",
                     $time, got.consumed, got.store_valid, got.store_char,
                     got.field_done, got.matched, got.value, got.end_seen);
          end
        end
      end
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (chars_if.valid && chars_if.ready) || (results_if.valid && results_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("** scanf_field_converter_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    plan_row_t plan[$];
    chars_if.valid = 1'b0;
    chars_if.ch = '0;
    chars_if.at_end = 1'b0;
    chars_if.restart = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.addr = '0;
    cfg_if.data = '0;
    plan = '{
      plan_check(CHAR_SPACE, 1'b0, 1'b1, outcome(1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 64'd0, 1'b0)),
      plan_check(CHAR_MINUS, 1'b0, 1'b0, outcome(1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 64'd0, 1'b0)),
      plan_check("1", 1'b0, 1'b0, outcome(1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 64'd0, 1'b0)),
      plan_check("2", 1'b0, 1'b0, outcome(1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 64'd0, 1'b0)),
      plan_check("x", 1'b0, 1'b0, outcome(1'b0, 1'b0, 8'h00, 1'b1, 1'b1, -64'sd12, 1'b0)),
      plan_check("z", 1'b0, 1'b0, outcome(1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 64'd0, 1'b0)),
      plan_write(REG_CONVERSION, 64'(CONV_UNS)),
      plan_check(CHAR_MINUS, 1'b0, 1'b1, outcome(1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 64'd0, 1'b0)),
      plan_write(REG_CONVERSION, 64'(CONV_HEX)),
      plan_write(REG_RESULT_SIZE, 64'(SIZE_SHORT)),
      plan_char("f", 1'b0, 1'b1),
      plan_char("F", 1'b0, 1'b0),
      plan_char("f", 1'b0, 1'b0),
      plan_char("F", 1'b0, 1'b0),
      plan_check(8'h00, 1'b1, 1'b0, outcome(1'b0, 1'b0, 8'h00, 1'b1, 1'b1, -64'sd1, 1'b1)),
      plan_write(REG_CONVERSION, 64'(CONV_OCT)),
      plan_write(REG_RESULT_SIZE, 64'(SIZE_LONG)),
      plan_write(REG_MAX_WIDTH, 64'd2),
      plan_char("7", 1'b0, 1'b1),
      plan_char("7", 1'b0, 1'b0),
      plan_check("7", 1'b0, 1'b0, outcome(1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 64'd63, 1'b0)),
      plan_write(REG_CONVERSION, 64'(CONV_NODIGIT)),
      plan_write(REG_MAX_WIDTH, 64'd0),
      plan_check(CHAR_TAB, 1'b0, 1'b1, outcome(1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 64'd0, 1'b0)),
      plan_check("5", 1'b0, 1'b0, outcome(1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 64'd0, 1'b0)),
      plan_write(REG_CONVERSION, 64'(CONV_FIXED)),
      plan_write(REG_STORE_ENABLE, 64'd0),
      plan_check(8'hFF, 1'b0, 1'b1, outcome(1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 64'd0, 1'b0)),
      plan_write(REG_CONVERSION, 64'(CONV_SET)),
      plan_write(REG_STORE_ENABLE, 64'd1),
      plan_write(REG_SET_BITS_A, 64'h0800_0000_0000_0000),
      plan_write(REG_SET_BITS_B, 64'd0),
      plan_write(REG_SET_BITS_C, 64'd0),
      plan_write(REG_SET_BITS_D, 64'h8000_0000_0000_0000),
      plan_check(CHAR_SPACE, 1'b0, 1'b1,
                 outcome(1'b1, 1'b1, CHAR_SPACE, 1'b0, 1'b0, 64'd0, 1'b0)),
      plan_check(8'h00, 1'b0, 1'b0, outcome(1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 64'd0, 1'b0)),
      plan_check(8'hFF, 1'b0, 1'b0, outcome(1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 64'd0, 1'b0)),
      plan_write(REG_CONVERSION, 64'(CONV_WORD)),
      plan_write(REG_RESULT_SIZE, 64'd3),
      plan_write(REG_MAX_WIDTH, 64'hFFFF),
      plan_check("A", 1'b0, 1'b1, outcome(1'b1, 1'b1, "A", 1'b0, 1'b0, 64'd0, 1'b0)),
      plan_check(CHAR_CR, 1'b0, 1'b0, outcome(1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 64'd0, 1'b0)),
      plan_write(REG_CONVERSION, 64'(CONV_DEC)),
      plan_write(REG_MAX_WIDTH, 64'd0),
      plan_check(8'h00, 1'b1, 1'b1, outcome(1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 64'd0, 1'b1))
    };
    repeat (5) @(negedge clk);
    rst = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (!cfg_if.valid) settle();
        write_reg(plan[i].addr, plan[i].data);
      end else begin
        cfg_if.valid = 1'b0;
        push_char(plan[i].ch, plan[i].at_end, plan[i].restart, plan[i].typed, plan[i].want);
      end
    end
    while (chars_sent < ITEM_TARGET) begin
      reconfigure();
      repeat ($urandom_range(3, 8)) send_field();
    end
    chars_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("** scanf_field_converter_unit: PASSED **");
    end else begin
      $display("** scanf_field_converter_unit: FAILED **");
    end
    $finish;
  end

endmodule
